// ----- sv/absiv_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package absiv_pkg;

    // Fixed image layout
    localparam int HDR_BYTES    = 20;
    localparam int DIGEST_BYTES = 32;
    localparam int FTR_BYTES    = 8;
    localparam int CAP_W        = 25;
    localparam int OUT_W        = 80;

    localparam logic [31:0] MAGIC_A     = 32'h5347_4144;
    localparam logic [31:0] MAGIC_B     = 32'h4653_4744;
    localparam logic [31:0] CRC_POLY    = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES    = 32'hFFFF_FFFF;
    localparam logic [15:0] IMG_VERSION = 16'd1;

    // Verdict codes
    localparam logic [1:0] ST_VALID  = 2'd0;
    localparam logic [1:0] ST_HEADER = 2'd1;
    localparam logic [1:0] ST_FOOTER = 2'd2;
    localparam logic [1:0] ST_FAULT  = 2'd3;

    // Slot table update, one per verdict
    typedef struct packed {
        logic        en;
        logic        slot;
        logic        ok;
        logic [31:0] gen;
    } t_upd;

    // Load/save choice after the update
    typedef struct packed {
        logic        load_found;
        logic        load_slot;
        logic        save_slot;
        logic [31:0] next_generation;
    } t_choice;

    // Result word, last field in the lowest bits
    typedef struct packed {
        logic        pad;
        logic [31:0] next_generation;
        logic        save_slot;
        logic        load_slot;
        logic        load_found;
        logic [8:0]  record_count;
        logic [31:0] generation;
        logic [1:0]  status;
        logic        verdict_slot;
    } t_result;

    // Reflected CRC-32, one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

`default_nettype wire

// ----- sv/absiv_select.sv -----
`timescale 1ns / 1ps
`default_nettype none

module absiv_select (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  absiv_pkg::t_upd     i_upd,
    output absiv_pkg::t_choice  o_choice
);
    import absiv_pkg::*;

    logic [1:0]  r_valid;
    logic [1:0]  n_valid;
    logic [31:0] r_gen [2];
    logic [31:0] n_gen [2];
    logic        g1_gt;
    logic        g0_gt;
    logic [31:0] maxg;

    // table as it stands after this verdict
    always_comb begin
        n_valid  = r_valid;
        n_gen[0] = r_gen[0];
        n_gen[1] = r_gen[1];
        if (i_upd.en) begin
            n_valid[i_upd.slot] = i_upd.ok;
            n_gen[i_upd.slot]   = i_upd.ok ? i_upd.gen : 32'd0;
        end
    end

    assign g1_gt = n_gen[1] > n_gen[0];
    assign g0_gt = n_gen[0] > n_gen[1];

    always_comb begin
        if (n_valid[0] && n_valid[1]) begin
            maxg = g1_gt ? n_gen[1] : n_gen[0];
        end else if (n_valid[0]) begin
            maxg = n_gen[0];
        end else if (n_valid[1]) begin
            maxg = n_gen[1];
        end else begin
            maxg = 32'd0;
        end
    end

    assign o_choice.load_found      = |n_valid;
    assign o_choice.load_slot       = n_valid[1] && (!n_valid[0] || g1_gt);
    assign o_choice.save_slot       = n_valid[0] && (!n_valid[1] || g0_gt);
    assign o_choice.next_generation = maxg + 32'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 2'b00;
            r_gen[0] <= 32'd0;
            r_gen[1] <= 32'd0;
        end else if (i_upd.en) begin
            r_valid  <= n_valid;
            r_gen[0] <= n_gen[0];
            r_gen[1] <= n_gen[1];
        end
    end

endmodule

`default_nettype wire

// ----- sv/ab_slot_image_verify_select.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Payload                                         Handshake
// s_axis    in   tdata: data_byte; tuser: slot, first, fault     tvalid/tready
// m_axis    out  tdata: verdict word (see port comment)          tvalid/tready
// cfg       in   i_cfg_wdata: slot_capacity                      i_cfg_we, no wait
//
// One byte per cycle while m_axis is not stalled. A byte is held in the input
// register, then the parse, CRC-32 and slot table update run combinationally into
// the result register, from which its verdict is shown. Reset (i_rst_n low,
// synchronous) idles the parser, marks both slots invalid and sets slot_capacity
// to 65536. A stall on m_axis holds the result; the input register still takes
// one byte, then s_axis_tready drops.

module ab_slot_image_verify_select #(
    parameter int RECORD_BYTES = 128,
    parameter int MAX_RECORDS  = 256
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // configuration
    input  logic                          i_cfg_we,
    input  logic [absiv_pkg::CAP_W-1:0]   i_cfg_wdata,
    // byte stream in
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // [7:0] data_byte
    input  logic [2:0]                    s_axis_tuser,   // [0] slot, [1] first, [2] read_fault
    // verdicts out
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] verdict_slot, [2:1] status, [34:3] generation, [43:35] record_count,
    // [44] load_found, [45] load_slot, [46] save_slot, [78:47] next_generation,
    // [79] zero
    output logic [absiv_pkg::OUT_W-1:0]   m_axis_tdata
);
    import absiv_pkg::*;

    // count width, record size width, record area length width
    localparam int CW  = $clog2(MAX_RECORDS + 1);
    localparam int RBW = $clog2(RECORD_BYTES + 1);
    localparam int LW  = CW + RBW;
    localparam int PW  = (LW > 6) ? LW : 6;
    localparam int TW  = ((LW > CAP_W) ? LW : CAP_W) + 7;
    localparam int HIW = $clog2(HDR_BYTES);
    localparam int FIW = $clog2(FTR_BYTES - 1);

    // parser phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_HEADER  = 3'd1;
    localparam logic [2:0] PH_RECORDS = 3'd2;
    localparam logic [2:0] PH_DIGEST  = 3'd3;
    localparam logic [2:0] PH_FOOTER  = 3'd4;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_slot;
    logic        r_in_first;
    logic        r_in_fault;

    // result register
    logic        r_out_valid;
    t_result     r_out;

    logic [CAP_W-1:0] r_cap;

    // parse state
    logic [2:0]    r_phase,    n_phase;
    logic [PW-1:0] r_pos,      n_pos;
    logic [31:0]   r_crc,      n_crc;
    logic          r_cur_slot, n_cur_slot;
    logic [LW-1:0] r_rec_len,  n_rec_len;
    logic          r_cnt_big,  n_cnt_big;
    logic [7:0]    r_hdr [HDR_BYTES];
    logic [7:0]    r_ftr [FTR_BYTES-1];

    logic          adv;
    logic          proc;
    logic          hdr_we;
    logic          ftr_we;
    logic          emit;
    logic [1:0]    emit_status;
    logic [2:0]    ph;
    logic [PW-1:0] pos;
    logic [31:0]   crc;
    logic [31:0]   w_count;
    logic [31:0]   w_gen;
    logic [31:0]   w_magic;
    logic [15:0]   w_version;
    logic [31:0]   w_rsize;
    logic [31:0]   w_stored;
    logic [31:0]   w_magic2;
    logic          hdr_ok;
    logic          ok;
    t_upd          upd;
    t_choice       choice;
    t_result       res;

    // result register frees when empty or being taken
    assign adv           = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || adv;
    assign proc          = r_in_valid && adv;

    // header fields, little-endian
    assign w_magic   = {r_hdr[3], r_hdr[2], r_hdr[1], r_hdr[0]};
    assign w_version = {r_hdr[5], r_hdr[4]};
    assign w_gen     = {r_hdr[11], r_hdr[10], r_hdr[9], r_hdr[8]};
    assign w_count   = {r_hdr[15], r_hdr[14], r_hdr[13], r_hdr[12]};
    // record size completes with the byte in hand (last header byte)
    assign w_rsize   = {r_in_byte, r_hdr[18], r_hdr[17], r_hdr[16]};
    assign w_stored  = {r_ftr[3], r_ftr[2], r_ftr[1], r_ftr[0]};
    assign w_magic2  = {r_in_byte, r_ftr[6], r_ftr[5], r_ftr[4]};

    // record area length is registered at header byte 16, before the header ends
    assign hdr_ok = (w_magic == MAGIC_A) && (w_version == IMG_VERSION)
                 && (w_rsize == 32'(RECORD_BYTES)) && !r_cnt_big
                 && (TW'(HDR_BYTES + DIGEST_BYTES + FTR_BYTES) + TW'(r_rec_len)
                     <= TW'(r_cap));

    // a first byte restarts the parse from header byte zero
    assign ph  = r_in_first ? PH_HEADER : r_phase;
    assign pos = r_in_first ? '0 : r_pos;
    assign crc = r_in_first ? ALL_ONES : r_crc;

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_crc       = r_crc;
        n_cur_slot  = r_cur_slot;
        n_rec_len   = r_rec_len;
        n_cnt_big   = r_cnt_big;
        hdr_we      = 1'b0;
        ftr_we      = 1'b0;
        emit        = 1'b0;
        emit_status = ST_VALID;
        if (proc) begin
            n_phase = ph;
            n_pos   = pos;
            n_crc   = crc;
            if (r_in_first) begin
                n_cur_slot = r_in_slot;
            end
            if (ph != PH_IDLE) begin
                if (r_in_fault) begin
                    emit        = 1'b1;
                    emit_status = ST_FAULT;
                    n_phase     = PH_IDLE;
                end else begin
                    unique case (ph)
                        PH_HEADER: begin
                            hdr_we = 1'b1;
                            n_crc  = crc_byte(crc, r_in_byte);
                            n_pos  = pos + PW'(1);
                            // count bytes 12..15 are all in by now
                            if (pos == PW'(16)) begin
                                n_cnt_big = w_count > 32'(MAX_RECORDS);
                                n_rec_len = LW'(w_count[CW-1:0]) * LW'(RECORD_BYTES);
                            end
                            if (pos == PW'(HDR_BYTES - 1)) begin
                                n_pos = '0;
                                if (!hdr_ok) begin
                                    emit        = 1'b1;
                                    emit_status = ST_HEADER;
                                    n_phase     = PH_IDLE;
                                end else if (r_rec_len != '0) begin
                                    n_phase = PH_RECORDS;
                                end else begin
                                    n_phase = PH_DIGEST;
                                end
                            end
                        end
                        PH_RECORDS: begin
                            n_crc = crc_byte(crc, r_in_byte);
                            if (pos + PW'(1) == PW'(r_rec_len)) begin
                                n_pos   = '0;
                                n_phase = PH_DIGEST;
                            end else begin
                                n_pos = pos + PW'(1);
                            end
                        end
                        PH_DIGEST: begin
                            // digest bytes are skipped, not checked
                            if (pos == PW'(DIGEST_BYTES - 1)) begin
                                n_pos   = '0;
                                n_phase = PH_FOOTER;
                            end else begin
                                n_pos = pos + PW'(1);
                            end
                        end
                        PH_FOOTER: begin
                            if (pos[FIW-1:0] == FIW'(FTR_BYTES - 1)) begin
                                emit        = 1'b1;
                                n_phase     = PH_IDLE;
                                emit_status = ((w_magic2 == MAGIC_B)
                                              && (w_stored == ~crc)) ? ST_VALID : ST_FOOTER;
                            end else begin
                                ftr_we = 1'b1;
                                n_pos  = pos + PW'(1);
                            end
                        end
                        default: begin
                            n_phase = PH_IDLE;
                        end
                    endcase
                end
            end
        end
    end

    assign ok = (emit_status == ST_VALID);

    assign upd.en   = emit;
    assign upd.slot = n_cur_slot;
    assign upd.ok   = ok;
    assign upd.gen  = w_gen;

    absiv_select u_select (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_upd    (upd),
        .o_choice (choice)
    );

    always_comb begin
        res                 = '0;
        res.verdict_slot    = n_cur_slot;
        res.status          = emit_status;
        res.generation      = ok ? w_gen : 32'd0;
        res.record_count    = ok ? w_count[8:0] : 9'd0;
        res.load_found      = choice.load_found;
        res.load_slot       = choice.load_slot;
        res.save_slot       = choice.save_slot;
        res.next_generation = choice.next_generation;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_cap       <= CAP_W'(65536);
            r_phase     <= PH_IDLE;
            r_pos       <= '0;
            r_crc       <= ALL_ONES;
            r_cur_slot  <= 1'b0;
            r_rec_len   <= '0;
            r_cnt_big   <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (proc && emit) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_crc      <= n_crc;
            r_cur_slot <= n_cur_slot;
            r_rec_len  <= n_rec_len;
            r_cnt_big  <= n_cnt_big;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte  <= s_axis_tdata;
            r_in_slot  <= s_axis_tuser[0];
            r_in_first <= s_axis_tuser[1];
            r_in_fault <= s_axis_tuser[2];
        end
        if (hdr_we) begin
            r_hdr[pos[HIW-1:0]] <= r_in_byte;
        end
        if (ftr_we) begin
            r_ftr[pos[FIW-1:0]] <= r_in_byte;
        end
        if (proc && emit) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out;

endmodule

`default_nettype wire

// ----- sv/absiv_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module absiv_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [absiv_pkg::OUT_W-1:0] m_axis_tdata
);
    import absiv_pkg::*;

    t_result res;
    assign res = t_result'(m_axis_tdata);

    // a valid verdict leaves at least one slot loadable
    a_valid_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status == ST_VALID) |-> res.load_found)
        else $error("valid verdict without a loadable slot");

    // nothing loadable means generation restarts at one
    a_empty_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !res.load_found) |-> (res.next_generation == 32'd1))
        else $error("next generation wrong with no valid slot");

    // rejected images report no header values
    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status != ST_VALID)
            |-> (res.generation == 32'd0 && res.record_count == 9'd0))
        else $error("rejected verdict carries header values");

    // the judged slot chosen for load sets the next generation
    a_load_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && res.status == ST_VALID && res.load_slot == res.verdict_slot)
            |-> (res.next_generation == res.generation + 32'd1))
        else $error("next generation does not follow the loaded slot");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result transfer changed");

endmodule

bind ab_slot_image_verify_select absiv_checker u_absiv_checker (.*);

`default_nettype wire

// ----- bench/ab_slot_image_verify_select_tb.sv -----
`timescale 1ns / 1ps

module ab_slot_image_verify_select_tb;
    import absiv_pkg::*;

    // Block configuration under test (defaults of the RTL)
    localparam int REC_BYTES = 128;
    localparam int MAX_RECS  = 256;

    // Parser position inside one image
    typedef enum logic [2:0] {
        PH_IDLE, PH_HEADER, PH_RECORDS, PH_DIGEST, PH_FOOTER
    } parse_e;

    // What kind of image the stimulus builds
    typedef enum int {
        IMG_GOOD, IMG_BAD_MAGIC, IMG_BAD_VERSION, IMG_BAD_RSIZE, IMG_BAD_COUNT,
        IMG_BAD_CRC, IMG_BAD_MAGIC2, IMG_FAULT, IMG_CUT
    } img_kind_e;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [CAP_W-1:0]   i_cfg_wdata;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [7:0]         s_axis_tdata;   // [7:0] data_byte
    logic [2:0]         s_axis_tuser;   // [0] slot, [1] first, [2] read_fault
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [OUT_W-1:0]   m_axis_tdata;   // t_result, verdict_slot in bit 0

    ab_slot_image_verify_select #(
        .RECORD_BYTES (REC_BYTES),
        .MAX_RECORDS  (MAX_RECS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // Run bookkeeping
    int mismatches         = 0;
    int bytes_taken        = 0;   // bytes the parser actually consumed
    int verdicts_predicted = 0;
    int send_idle_pct      = 0;
    int recv_idle_pct      = 0;

    t_result verdicts_due[$];     // expected verdicts, oldest first

    // Predicted parser and slot table state, reset values
    parse_e           pr_phase     = PH_IDLE;
    logic [31:0]      pr_pos       = '0;
    logic [63:0]      pr_hdr [3]   = '{default: '0};
    logic [31:0]      pr_crc       = ALL_ONES;
    logic [63:0]      pr_ftr       = '0;
    logic             pr_slot      = 1'b0;
    logic [CAP_W-1:0] cap_bytes    = 25'd65536;
    logic             slot_ok [2]  = '{1'b0, 1'b0};
    logic [31:0]      slot_gen [2] = '{32'd0, 32'd0};
    logic [8:0]       slot_recs [2] = '{9'd0, 9'd0};

    // ------------------------------------------------------------------
    // Clock, timeout
    // ------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #(5_000_000);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------

    // Reflected CRC-32, fed one data bit at a time
    function automatic logic [31:0] crc32_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] r;
        r = c;
        for (int k = 0; k < 8; k++)
            r = (r >> 1) ^ (((r[0] ^ b[k]) != 1'b0) ? CRC_POLY : 32'd0);
        return r;
    endfunction

    function automatic bit header_passes();
        logic [31:0] n;
        logic [63:0] need;
        n = pr_hdr[1][63:32];
        if (pr_hdr[0][31:0] != MAGIC_A || pr_hdr[0][47:32] != IMG_VERSION ||
                pr_hdr[2][31:0] != REC_BYTES)
            return 1'b0;
        if (n > MAX_RECS)
            return 1'b0;
        // header + records + digest + footer must fit in one slot
        need = 64'(HDR_BYTES) + 64'(n) * REC_BYTES + DIGEST_BYTES + FTR_BYTES;
        return need <= 64'(cap_bytes);
    endfunction

    // Record a verdict for the latched slot and queue the resulting choice
    function automatic void post_verdict(input logic [1:0] st);
        t_result     r;
        logic        ok;
        logic [31:0] top_gen;
        ok = (st == ST_VALID);
        slot_ok[pr_slot]   = ok;
        slot_gen[pr_slot]  = ok ? pr_hdr[1][31:0] : 32'd0;
        slot_recs[pr_slot] = ok ? pr_hdr[1][40:32] : 9'd0;
        pr_phase = PH_IDLE;

        top_gen = 32'd0;
        if (slot_ok[0] && slot_gen[0] > top_gen) top_gen = slot_gen[0];
        if (slot_ok[1] && slot_gen[1] > top_gen) top_gen = slot_gen[1];

        r = '0;
        r.verdict_slot = pr_slot;
        r.status       = st;
        r.generation   = slot_gen[pr_slot];
        r.record_count = slot_recs[pr_slot];
        r.load_found   = slot_ok[0] | slot_ok[1];
        r.load_slot    = slot_ok[1] && (!slot_ok[0] || slot_gen[1] > slot_gen[0]);
        // overwrite the first invalid slot, else the older one (slot 0 on a tie)
        if (!slot_ok[0])
            r.save_slot = 1'b0;
        else if (!slot_ok[1])
            r.save_slot = 1'b1;
        else
            r.save_slot = (slot_gen[0] > slot_gen[1]);
        r.next_generation = top_gen + 32'd1;   // wraps at 32 bits
        verdicts_due.push_back(r);
        verdicts_predicted++;
    endfunction

    // Advance the predicted parser by one transferred byte; 0 if it was ignored
    function automatic bit predict_byte(input logic slot, input logic is_first,
                                        input logic [7:0] b, input logic fault);
        logic [31:0] p;
        if (is_first) begin
            pr_phase = PH_HEADER;
            pr_pos   = '0;
            pr_hdr   = '{default: '0};
            pr_crc   = ALL_ONES;
            pr_ftr   = '0;
            pr_slot  = slot;
        end else if (pr_phase == PH_IDLE) begin
            return 1'b0;
        end

        if (fault) begin
            post_verdict(ST_FAULT);
            return 1'b1;
        end

        case (pr_phase)
            PH_HEADER: begin
                p = pr_pos;
                pr_hdr[p[4:3]][p[2:0] * 8 +: 8] = b;
                pr_crc = crc32_step(pr_crc, b);
                pr_pos = p + 1;
                if (pr_pos >= HDR_BYTES) begin
                    if (!header_passes()) begin
                        post_verdict(ST_HEADER);
                    end else begin
                        pr_pos = '0;
                        // zero records: digest follows the header directly
                        if (pr_hdr[1][63:32] != 0)
                            pr_phase = PH_RECORDS;
                        else
                            pr_phase = PH_DIGEST;
                    end
                end
            end
            PH_RECORDS: begin
                pr_crc = crc32_step(pr_crc, b);
                pr_pos++;
                if (64'(pr_pos) >= 64'(pr_hdr[1][63:32]) * REC_BYTES) begin
                    pr_pos   = '0;
                    pr_phase = PH_DIGEST;
                end
            end
            PH_DIGEST: begin
                pr_pos++;
                if (pr_pos >= DIGEST_BYTES) begin
                    pr_pos   = '0;
                    pr_phase = PH_FOOTER;
                end
            end
            PH_FOOTER: begin
                p = pr_pos & 32'd7;
                pr_ftr[p[2:0] * 8 +: 8] = b;
                pr_pos = p + 1;
                if (pr_pos >= FTR_BYTES) begin
                    if (pr_ftr[63:32] == MAGIC_B && pr_ftr[31:0] == ~pr_crc)
                        post_verdict(ST_VALID);
                    else
                        post_verdict(ST_FOOTER);
                end
            end
            default: pr_phase = PH_IDLE;
        endcase
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void note_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] seen);
        mismatches++;
        if (mismatches <= 10)
            $display("%0t: verdict %s: expected %h, got %h", $time, what, want, seen);
    endfunction

    always @(posedge i_clk) begin : verdict_checker
        t_result want;
        t_result seen;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen = m_axis_tdata;
            if (verdicts_due.size() == 0) begin
                note_mismatch("transfer with nothing pending, status", 32'd0, 32'(seen.status));
            end else begin
                want = verdicts_due.pop_front();
                if (seen.verdict_slot !== want.verdict_slot)
                    note_mismatch("verdict_slot", 32'(want.verdict_slot), 32'(seen.verdict_slot));
                if (seen.status !== want.status)
                    note_mismatch("status", 32'(want.status), 32'(seen.status));
                if (seen.generation !== want.generation)
                    note_mismatch("generation", want.generation, seen.generation);
                if (seen.record_count !== want.record_count)
                    note_mismatch("record_count", 32'(want.record_count), 32'(seen.record_count));
                if (seen.load_found !== want.load_found)
                    note_mismatch("load_found", 32'(want.load_found), 32'(seen.load_found));
                if (seen.load_slot !== want.load_slot)
                    note_mismatch("load_slot", 32'(want.load_slot), 32'(seen.load_slot));
                if (seen.save_slot !== want.save_slot)
                    note_mismatch("save_slot", 32'(want.save_slot), 32'(seen.save_slot));
                if (seen.next_generation !== want.next_generation)
                    note_mismatch("next_generation", want.next_generation,
                                  seen.next_generation);
                if (seen.pad !== 1'b0)
                    note_mismatch("pad bit", 32'd0, 32'(seen.pad));
            end
        end
    end

    // Receiver: stalls m_axis at the rate set by the running test
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // One s_axis transfer. Returns at the accepting edge with tvalid still high;
    // the next call either replaces the data or opens a gap.
    task automatic send_byte(input logic slot, input logic is_first,
                             input logic [7:0] b, input logic fault);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= {fault, is_first, slot};
        do @(posedge i_clk); while (!s_axis_tready);
        if (predict_byte(slot, is_first, b, fault))
            bytes_taken++;
    endtask

    // Sender pauses until every pending verdict is out, plus pipeline slack
    task automatic wait_verdicts_done();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdicts_due.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] v);
        wait_verdicts_done();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cap_bytes = v;
    endtask

    function automatic logic [CAP_W-1:0] random_capacity();
        case ($urandom_range(3))
            0:       return 25'd64;
            // exact fit for 1..3 records, or one byte short
            1:       return 25'(60 + REC_BYTES * $urandom_range(1, 3) - $urandom_range(0, 1));
            2:       return 25'd65536;
            default: return 25'($urandom_range(64, 1 << 24));
        endcase
    endfunction

    function automatic void push_le(ref logic [7:0] q[$], input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            q.push_back(v[i * 8 +: 8]);
    endfunction

    // Build one slot image (optionally damaged) and stream it out.
    // Bytes that are not first carry a random slot bit, which the block ignores.
    task automatic send_image(input logic slot, input logic [31:0] gen,
                              input logic [31:0] count, input img_kind_e kind);
        logic [7:0]  img[$];
        logic [31:0] sum;
        int          n_send;
        int          fault_at;
        push_le(img, (kind == IMG_BAD_MAGIC) ? MAGIC_A ^ (32'd1 << $urandom_range(31))
                                              : MAGIC_A, 4);
        push_le(img, (kind == IMG_BAD_VERSION) ? 32'(IMG_VERSION ^ (16'd1 << $urandom_range(15)))
                                                : 32'(IMG_VERSION), 2);
        push_le(img, $urandom, 2);   // reserved, never checked
        push_le(img, gen, 4);
        push_le(img, count, 4);
        push_le(img, (kind == IMG_BAD_RSIZE) ? 32'(REC_BYTES) ^ (32'd1 << $urandom_range(31))
                                              : 32'(REC_BYTES), 4);
        if (count <= MAX_RECS)
            repeat (count * REC_BYTES) img.push_back(8'($urandom));
        sum = ALL_ONES;
        foreach (img[i])
            sum = crc32_step(sum, img[i]);
        repeat (DIGEST_BYTES) img.push_back(8'($urandom));
        push_le(img, (kind == IMG_BAD_CRC) ? ~sum ^ (32'd1 << $urandom_range(31)) : ~sum, 4);
        push_le(img, (kind == IMG_BAD_MAGIC2) ? MAGIC_B ^ (32'd1 << $urandom_range(31))
                                               : MAGIC_B, 4);

        fault_at = -1;
        case (kind)
            // header verdict lands on byte 20; up to three bytes after it are ignored
            IMG_BAD_MAGIC, IMG_BAD_VERSION, IMG_BAD_RSIZE, IMG_BAD_COUNT:
                n_send = HDR_BYTES + $urandom_range(0, 3);
            IMG_FAULT: begin
                fault_at = $urandom_range(0, img.size() - 1);
                n_send   = fault_at + 1 + $urandom_range(0, 2);
            end
            // cut short; the next first byte drops this parse
            IMG_CUT: n_send = $urandom_range(1, img.size() - 1);
            // whole image, then up to two stray bytes past the footer
            default: n_send = img.size() + $urandom_range(0, 2);
        endcase

        for (int i = 0; i < n_send; i++)
            send_byte((i == 0) ? slot : 1'($urandom_range(1)), i == 0,
                      (i < img.size()) ? img[i] : 8'($urandom), i == fault_at);
    endtask

    task automatic random_image();
        logic        slot;
        logic [31:0] gen;
        logic [31:0] count;
        img_kind_e   kind;
        int          pick;
        slot = 1'($urandom_range(1));
        case ($urandom_range(4))
            0:       gen = 32'd0;
            1:       gen = ALL_ONES;
            2:       gen = slot_gen[~slot];      // tie with the other slot
            3:       gen = $urandom_range(0, 7);
            default: gen = $urandom;
        endcase
        pick  = $urandom_range(99);
        count = (pick < 75) ? 32'd0 : (pick < 95) ? 32'd1 : 32'($urandom_range(2, 3));
        pick  = $urandom_range(99);
        if (pick < 40)      kind = IMG_GOOD;
        else if (pick < 45) kind = IMG_BAD_MAGIC;
        else if (pick < 50) kind = IMG_BAD_VERSION;
        else if (pick < 55) kind = IMG_BAD_RSIZE;
        else if (pick < 60) kind = IMG_BAD_COUNT;
        else if (pick < 68) kind = IMG_BAD_CRC;
        else if (pick < 75) kind = IMG_BAD_MAGIC2;
        else if (pick < 90) kind = IMG_FAULT;
        else                kind = IMG_CUT;
        if (kind == IMG_BAD_COUNT) begin
            case ($urandom_range(2))
                0:       count = MAX_RECS + 1;
                1:       count = ALL_ONES;
                default: count = $urandom_range(MAX_RECS + 1, 32'hFFFF_FFFE);
            endcase
        end
        send_image(slot, gen, count, kind);
        // occasional line noise: continues a cut parse or is dropped while idle
        if ($urandom_range(9) == 0)
            repeat ($urandom_range(1, 4))
                send_byte(1'($urandom_range(1)), 1'b0, 8'($urandom), 1'($urandom_range(1)));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Bytes without first while idle, faulty or not, produce nothing
    task automatic test_ignored_bytes();
        send_byte(1'b0, 1'b0, 8'hFF, 1'b0);
        send_byte(1'b1, 1'b0, 8'h00, 1'b1);
        send_byte(1'b1, 1'b0, 8'hA5, 1'b0);
        wait_verdicts_done();
    endtask

    task automatic test_read_faults();
        send_byte(1'b1, 1'b1, 8'h44, 1'b1);          // fault on the first byte
        send_byte(1'b0, 1'b0, 8'h41, 1'b0);          // parser idle again: dropped
        send_image(1'b0, 32'd1, 32'd0, IMG_FAULT);
        send_image(1'b1, 32'd7, 32'd1, IMG_FAULT);
        wait_verdicts_done();
    endtask

    task automatic test_header_checks();
        send_image(1'b0, 32'd3, 32'd0, IMG_BAD_MAGIC);
        send_image(1'b1, 32'd3, 32'd0, IMG_BAD_VERSION);
        send_image(1'b0, 32'd3, 32'd1, IMG_BAD_RSIZE);
        send_image(1'b1, 32'd3, MAX_RECS + 1, IMG_BAD_COUNT);
        send_image(1'b0, 32'd3, ALL_ONES, IMG_BAD_COUNT);
        wait_verdicts_done();
    endtask

    task automatic test_slot_selection();
        send_image(1'b0, 32'd0, 32'd0, IMG_GOOD);     // first valid slot
        send_image(1'b1, ALL_ONES, 32'd1, IMG_GOOD);  // newest; next generation wraps
        send_image(1'b0, ALL_ONES, 32'd0, IMG_GOOD);  // equal generations
        send_image(1'b1, 32'd5, 32'd0, IMG_BAD_CRC);
        send_image(1'b1, 32'd6, 32'd0, IMG_BAD_MAGIC2);
        send_image(1'b0, 32'd9, 32'd1, IMG_CUT);      // dropped by the restart below
        send_image(1'b0, 32'd3, 32'd0, IMG_GOOD);
        send_image(1'b1, 32'd2, 32'd2, IMG_GOOD);
        wait_verdicts_done();
    endtask

    task automatic test_slot_capacity();
        write_capacity(25'd64);                       // smallest slot: header + digest + footer only
        send_image(1'b0, 32'd10, 32'd0, IMG_GOOD);
        send_image(1'b1, 32'd11, 32'd1, IMG_GOOD);
        write_capacity(25'd316);                      // exactly two records
        send_image(1'b1, 32'd12, 32'd2, IMG_GOOD);
        send_image(1'b0, 32'd13, 32'd3, IMG_GOOD);
        write_capacity(25'd315);
        send_image(1'b0, 32'd14, 32'd2, IMG_GOOD);
        write_capacity(25'd16777216);                 // largest slot, fullest image
        send_image(1'b1, 32'h8000_0000, MAX_RECS, IMG_GOOD);
        write_capacity(25'd65536);
    endtask

    task automatic run_random_phase(input int s_pct, input int r_pct);
        int start_bytes;
        int start_verdicts;
        send_idle_pct  = s_pct;
        recv_idle_pct  = r_pct;
        start_bytes    = bytes_taken;
        start_verdicts = verdicts_predicted;
        write_capacity(random_capacity());
        while (bytes_taken - start_bytes < 470 || verdicts_predicted - start_verdicts < 10) begin
            random_image();
            // sometimes let everything drain and move to a new slot size
            if ($urandom_range(14) == 0)
                write_capacity(random_capacity());
        end
        wait_verdicts_done();
    endtask

    task automatic test_random_traffic();
        run_random_phase(16, 86);
        run_random_phase(86, 16);
        run_random_phase(0, 0);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_seq
        int tail;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_bytes();
        test_read_faults();
        test_header_checks();
        test_slot_selection();
        test_slot_capacity();
        test_random_traffic();

        s_axis_tvalid <= 1'b0;
        tail = 0;
        while (verdicts_due.size() != 0 && tail < 200000) begin
            @(posedge i_clk);
            tail++;
        end
        if (verdicts_due.size() != 0)
            $display("%0d expected verdicts never arrived", verdicts_due.size());
        mismatches += verdicts_due.size();
        repeat (10) @(posedge i_clk);   // catch any stray transfer

        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
sv/absiv_pkg.sv
sv/absiv_select.sv
sv/ab_slot_image_verify_select.sv
sv/absiv_checker.sv
bench/ab_slot_image_verify_select_tb.sv
